// ===== rtl/udrb_pkg.sv =====
package udrb_pkg;

  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 6;

  localparam int SEND_DEPTH_DEF    = 64;
  localparam int RECEIVE_DEPTH_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_HOST_WRITE = 2'd0,
    CMD_HOST_READ  = 2'd1,
    CMD_LINE_RX    = 2'd2,
    CMD_TX_READY   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== rtl/udrb_ram.sv =====
module udrb_ram #(
  parameter int DEPTH = udrb_pkg::SEND_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [udrb_pkg::BYTE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [udrb_pkg::BYTE_W-1:0] rdata
);
  import udrb_pkg::*;

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // registered read port, data held until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/uart_dual_ring_buffer.sv =====
// a result is registered and shown in the cycle after its item is accepted
// throughput: one item per cycle; input is held off only while a result is stalled
// each item does at most one pointer update and at most one access to one of the two
// byte memories (write for a push, registered read for a pop)
// reset (synchronous, active low) clears pointers, transmit request and output valid;
// the byte memories are not cleared and need no clearing pass
module uart_dual_ring_buffer #(
  parameter int SEND_DEPTH    = udrb_pkg::SEND_DEPTH_DEF,
  parameter int RECEIVE_DEPTH = udrb_pkg::RECEIVE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [udrb_pkg::CMD_W-1:0]    in_command,
  input  logic [udrb_pkg::BYTE_W-1:0]   in_data_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [udrb_pkg::STATUS_W-1:0] out_status,
  output logic [udrb_pkg::BYTE_W-1:0]   out_read_byte,
  output logic                          out_send_valid,
  output logic [udrb_pkg::BYTE_W-1:0]   out_send_byte,
  output logic                          out_transmit_request,
  output logic [udrb_pkg::COUNT_W-1:0]  out_receive_count
);
  import udrb_pkg::*;

  localparam int TAW = $clog2(SEND_DEPTH);
  localparam int RAW = $clog2(RECEIVE_DEPTH);
  localparam int RCW = RAW + 1;   // room for depth plus head during wrap fix

  // pointer state, head and tail per queue
  logic [TAW-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [RAW-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic           req_r, req_nxt;

  // output register: status and flags, popped bytes come from the memory read ports
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic                rx_pop_r, rx_pop_nxt;
  logic                tx_pop_r, tx_pop_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  // memory port controls
  logic           tx_we, tx_re, rx_we, rx_re;
  logic [TAW-1:0] tx_head_inc, tx_tail_inc;
  logic [RAW-1:0] rx_head_inc, rx_tail_inc;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata;
  logic [RCW-1:0] rx_wait;
  logic           accept;
  cmd_t           cmd;

  // next slot, wrapping at the depth (depth need not be a power of two)
  assign tx_head_inc = (tx_head_r == TAW'(SEND_DEPTH - 1))    ? '0 : tx_head_r + 1'b1;
  assign tx_tail_inc = (tx_tail_r == TAW'(SEND_DEPTH - 1))    ? '0 : tx_tail_r + 1'b1;
  assign rx_head_inc = (rx_head_r == RAW'(RECEIVE_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
  assign rx_tail_inc = (rx_tail_r == RAW'(RECEIVE_DEPTH - 1)) ? '0 : rx_tail_r + 1'b1;

  // a new item may enter when the output register is empty or being taken;
  // the memory read data is then free to be replaced at the same edge
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cmd      = cmd_t'(in_command);

  // command decode and queue update
  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    req_nxt     = req_r;
    status_nxt  = ST_DONE;
    rx_pop_nxt  = 1'b0;
    tx_pop_nxt  = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    unique case (cmd)
      CMD_HOST_WRITE: begin
        // one slot stays empty: full when the advanced head meets the tail
        if (tx_head_inc == tx_tail_r) begin
          status_nxt = ST_FULL;
        end else begin
          tx_we       = accept;
          tx_head_nxt = tx_head_inc;
          req_nxt     = 1'b1;
        end
      end
      CMD_HOST_READ: begin
        if (rx_head_r == rx_tail_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          rx_re       = accept;
          rx_tail_nxt = rx_tail_inc;
          rx_pop_nxt  = 1'b1;
        end
      end
      CMD_LINE_RX: begin
        if (rx_head_inc == rx_tail_r) begin
          status_nxt = ST_FULL;
        end else begin
          rx_we       = accept;
          rx_head_nxt = rx_head_inc;
        end
      end
      CMD_TX_READY: begin
        if (tx_head_r == tx_tail_r) begin
          req_nxt    = 1'b0;
          status_nxt = ST_EMPTY;
        end else begin
          tx_re       = accept;
          tx_tail_nxt = tx_tail_inc;
          tx_pop_nxt  = 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // bytes waiting in the receive queue after this item
  always_comb begin
    if (rx_head_nxt >= rx_tail_nxt) begin
      rx_wait = {1'b0, rx_head_nxt} - {1'b0, rx_tail_nxt};
    end else begin
      rx_wait = RCW'(RECEIVE_DEPTH) + {1'b0, rx_head_nxt} - {1'b0, rx_tail_nxt};
    end
    count_nxt = COUNT_W'(rx_wait);
  end

  assign out_valid_nxt = accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r   <= '0;
      tx_tail_r   <= '0;
      rx_head_r   <= '0;
      rx_tail_r   <= '0;
      req_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rx_pop_r    <= 1'b0;
      tx_pop_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        req_r     <= req_nxt;
        rx_pop_r  <= rx_pop_nxt;
        tx_pop_r  <= tx_pop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      count_r  <= count_nxt;
    end
  end

  // a pop only reads a slot written at an earlier edge (the queue is non-empty),
  // and one item touches one memory once, so no forwarding is needed
  udrb_ram #(
    .DEPTH (SEND_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_head_inc),
    .wdata (in_data_byte),
    .re    (tx_re),
    .raddr (tx_tail_inc),
    .rdata (tx_rdata)
  );

  udrb_ram #(
    .DEPTH (RECEIVE_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_head_inc),
    .wdata (in_data_byte),
    .re    (rx_re),
    .raddr (rx_tail_inc),
    .rdata (rx_rdata)
  );

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_read_byte        = rx_pop_r ? rx_rdata : '0;
  assign out_send_valid       = tx_pop_r;
  assign out_send_byte        = tx_pop_r ? tx_rdata : '0;
  assign out_transmit_request = req_r;
  assign out_receive_count    = count_r;

endmodule

// ===== rtl/udrb_chk.sv =====
module udrb_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [udrb_pkg::CMD_W-1:0]    in_command,
  input logic [udrb_pkg::BYTE_W-1:0]   in_data_byte,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [udrb_pkg::STATUS_W-1:0] out_status,
  input logic [udrb_pkg::BYTE_W-1:0]   out_read_byte,
  input logic                          out_send_valid,
  input logic [udrb_pkg::BYTE_W-1:0]   out_send_byte,
  input logic                          out_transmit_request,
  input logic [udrb_pkg::COUNT_W-1:0]  out_receive_count
);
  import udrb_pkg::*;

  // every accepted item shows its result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item gave no result next cycle");

  // a byte can only be waiting to send while the transmit request is on
  a_send_req: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_valid) |-> (out_transmit_request && out_status == ST_DONE))
    else $error("byte sent with transmit request off");

  // a rejected or dropped byte pops nothing
  a_full_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (!out_send_valid && out_read_byte == '0))
    else $error("full status with a popped byte");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_read_byte) && $stable(out_send_byte)
      && $stable(out_receive_count)))
    else $error("stalled result changed");

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_command)
      && $stable(in_data_byte)))
    else $error("stalled input item changed");

endmodule

bind uart_dual_ring_buffer udrb_chk u_udrb_chk (.*);

// ===== tb/tb_uart_dual_ring_buffer.sv =====
`timescale 1ns / 1ps

module tb_uart_dual_ring_buffer;
  import udrb_pkg::*;

  localparam int TX_DEPTH = SEND_DEPTH_DEF;
  localparam int RX_DEPTH = RECEIVE_DEPTH_DEF;

  // what one result item should look like
  typedef struct {
    status_t             status;
    logic [BYTE_W-1:0]   read_byte;
    logic                send_valid;
    logic [BYTE_W-1:0]   send_byte;
    logic                tx_request;
    logic [COUNT_W-1:0]  rx_count;
  } uart_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_read_byte;
  logic                out_send_valid;
  logic [BYTE_W-1:0]   out_send_byte;
  logic                out_transmit_request;
  logic [COUNT_W-1:0]  out_receive_count;

  uart_dual_ring_buffer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_read_byte        (out_read_byte),
    .out_send_valid       (out_send_valid),
    .out_send_byte        (out_send_byte),
    .out_transmit_request (out_transmit_request),
    .out_receive_count    (out_receive_count)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // shadow copy of both ring buffers
  logic [BYTE_W-1:0] tx_ring [TX_DEPTH];
  logic [BYTE_W-1:0] rx_ring [RX_DEPTH];
  int                tx_head, tx_tail, rx_head, rx_tail;
  logic              tx_request;

  // results still owed by the block, oldest first
  uart_result_t expected_results [$];

  int errors       = 0;
  int items_sent   = 0;
  int full_hits    = 0;
  int empty_hits   = 0;
  int bytes_popped = 0;
  int bytes_read   = 0;

  // sender burst control
  bit sender_idle_on = 1'b1;
  int burst_left     = 0;

  // receiver stall pattern and long hold-off
  int rx_stall_pct = 30;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int rx_run_left  = 0;
  bit rx_state     = 1'b0;

  function automatic int next_slot(int p, int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  // advance the shadow state by one command and queue the result it causes
  task automatic predict_command(cmd_t cmd, logic [BYTE_W-1:0] data);
    uart_result_t r;
    int           n;
    int           waiting;
    r.status     = ST_DONE;
    r.read_byte  = '0;
    r.send_valid = 1'b0;
    r.send_byte  = '0;
    case (cmd)
      CMD_HOST_WRITE: begin
        n = next_slot(tx_head, TX_DEPTH);
        // full transmit queue rejects the byte, request untouched
        if (n == tx_tail) begin
          r.status = ST_FULL;
        end else begin
          tx_ring[n] = data;
          tx_head    = n;
          tx_request = 1'b1;
        end
      end
      CMD_HOST_READ: begin
        if (rx_head == rx_tail) begin
          r.status = ST_EMPTY;
        end else begin
          n           = next_slot(rx_tail, RX_DEPTH);
          r.read_byte = rx_ring[n];
          rx_tail     = n;
        end
      end
      CMD_LINE_RX: begin
        n = next_slot(rx_head, RX_DEPTH);
        // full receive queue drops the line byte
        if (n == rx_tail) begin
          r.status = ST_FULL;
        end else begin
          rx_ring[n] = data;
          rx_head    = n;
        end
      end
      default: begin
        // transmitter ready with nothing queued turns the request off
        if (tx_head == tx_tail) begin
          tx_request = 1'b0;
          r.status   = ST_EMPTY;
        end else begin
          n            = next_slot(tx_tail, TX_DEPTH);
          r.send_byte  = tx_ring[n];
          r.send_valid = 1'b1;
          tx_tail      = n;
        end
      end
    endcase
    waiting      = (rx_head >= rx_tail) ? rx_head - rx_tail : RX_DEPTH + rx_head - rx_tail;
    r.tx_request = tx_request;
    r.rx_count   = waiting[COUNT_W-1:0];
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_EMPTY) empty_hits++;
    if (r.send_valid) bytes_popped++;
    if (cmd == CMD_HOST_READ && r.status == ST_DONE) bytes_read++;
    expected_results.push_back(r);
  endtask

  // offer one item from a falling edge; returns at the falling edge after acceptance
  // valid stays high so the next item can follow without a gap
  task automatic send_item(cmd_t cmd, logic [BYTE_W-1:0] data);
    int gap;
    if (sender_idle_on && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(cmd, data);
    items_sent++;
    @(negedge clk);
  endtask

  // push_pct picks writes and line bytes over reads and transmitter ready
  function automatic cmd_t pick_command(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return ($urandom_range(0, 1) != 0) ? CMD_HOST_WRITE : CMD_LINE_RX;
    else
      return ($urandom_range(0, 1) != 0) ? CMD_HOST_READ : CMD_TX_READY;
  endfunction

  task automatic send_random(int count, int push_pct);
    repeat (count) send_item(pick_command(push_pct), BYTE_W'($urandom_range(0, 255)));
  endtask

  // receiver: long hold-off on request, otherwise random runs of stall / no stall
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_state    = ($urandom_range(0, 99) < rx_stall_pct);
        rx_run_left = $urandom_range(1, 10);
      end
      rx_run_left--;
      out_stall <= rx_state;
    end
  end

  task automatic check_field(string fname, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker, compares each accepted result with the oldest expectation
  always @(posedge clk) begin
    uart_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual status %0d",
                 $time, out_status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", BYTE_W'(e.status), BYTE_W'(out_status));
        check_field("read_byte", e.read_byte, out_read_byte);
        check_field("send_valid", BYTE_W'(e.send_valid), BYTE_W'(out_send_valid));
        check_field("send_byte", e.send_byte, out_send_byte);
        check_field("transmit_request", BYTE_W'(e.tx_request), BYTE_W'(out_transmit_request));
        check_field("receive_count", BYTE_W'(e.rx_count), BYTE_W'(out_receive_count));
      end
    end
  end

  // extremes of the byte, every command, empty and request-clearing cases
  task automatic test_directed();
    rx_stall_pct = 30;
    send_item(CMD_HOST_READ, 8'hFF);   // read of empty receive queue
    send_item(CMD_TX_READY, 8'h00);    // transmitter ready, nothing queued
    send_item(CMD_LINE_RX, 8'h00);
    send_item(CMD_LINE_RX, 8'hFF);
    send_item(CMD_LINE_RX, 8'hA5);
    send_item(CMD_HOST_READ, 8'h00);
    send_item(CMD_HOST_READ, 8'h5A);
    send_item(CMD_HOST_READ, 8'hFF);
    send_item(CMD_HOST_READ, 8'h00);   // empty again
    send_item(CMD_HOST_WRITE, 8'hFF);  // raises the request
    send_item(CMD_HOST_WRITE, 8'h00);
    send_item(CMD_HOST_WRITE, 8'h5A);
    send_item(CMD_TX_READY, 8'hFF);
    send_item(CMD_TX_READY, 8'h00);
    send_item(CMD_TX_READY, 8'h33);
    send_item(CMD_TX_READY, 8'hFF);    // drained, clears the request
    send_item(CMD_HOST_WRITE, 8'h81);
    send_item(CMD_HOST_READ, 8'hC3);   // receive empty while transmit holds a byte
    send_item(CMD_LINE_RX, 8'h7E);
    send_item(CMD_TX_READY, 8'h00);
    send_item(CMD_TX_READY, 8'h00);
    send_item(CMD_HOST_READ, 8'h00);
  endtask

  task automatic test_random_mix();
    rx_stall_pct = 30;
    send_random(300, 50);
  endtask

  // push-heavy phases run both queues into full, pop-heavy ones back to empty
  task automatic test_fill_drain();
    repeat (2) begin
      rx_stall_pct = 50;
      send_random(250, 85);
      rx_stall_pct = 20;
      send_random(250, 15);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    sender_idle_on = 1'b0;
    rx_hold_req    = 300;
    send_random(120, 60);
    sender_idle_on = 1'b1;
  endtask

  // back to back items with the receiver stall percentage set to zero
  task automatic test_full_rate();
    sender_idle_on = 1'b0;
    rx_stall_pct   = 0;
    send_random(160, 55);
    sender_idle_on = 1'b1;
    rx_stall_pct   = 30;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_HOST_WRITE;
    in_data_byte = '0;
    tx_head      = 0;
    tx_tail      = 0;
    rx_head      = 0;
    rx_tail      = 0;
    tx_request   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_mix();
    test_fill_drain();
    test_backpressure();
    test_full_rate();

    in_valid <= 1'b0;
    // drain what is still owed, then wait for anything stray
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d items: %0d full rejections, %0d empty replies", items_sent,
             full_hits, empty_hits);
    $display("%0d bytes sent to line, %0d bytes read by host, %0d mismatches",
             bytes_popped, bytes_read, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/udrb_pkg.sv
rtl/udrb_ram.sv
rtl/uart_dual_ring_buffer.sv
rtl/udrb_chk.sv
tb/tb_uart_dual_ring_buffer.sv
